// File: hdl/msd_pkg.sv
// Shared types, constants and the quarter-wave sine generator for the
// modulated stereo delay. No dependencies.
package msd_pkg;

	localparam int LINE_DEPTH_DEF      = 32768;
	localparam int SAMPLE_BITS_DEF     = 24;
	localparam int SINE_TABLE_BITS_DEF = 8;

	localparam int PHASE_W = 32;
	localparam int BASE_W  = 23;
	localparam int DEPTH_W = 14;
	localparam int GAIN_W  = 16;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 23;
	localparam int DLY_W   = 25;

	localparam logic [PHASE_W-1:0] LFO_L_INC = 32'd6817;
	localparam logic [PHASE_W-1:0] LFO_R_INC = 32'd10713;
	localparam logic [14:0] SIX_TENTHS_Q15 = 15'd19661;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic [BASE_W-1:0]  LEFT_BASE_RST  = 23'd3951360;
	localparam logic [BASE_W-1:0]  RIGHT_BASE_RST = 23'd5531904;
	localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST  = 14'd4608;
	localparam logic [GAIN_W-1:0]  FB_GAIN_RST    = 16'd7209;
	localparam logic [GAIN_W-1:0]  WET_GAIN_RST   = 16'd8192;

	typedef enum logic [CFG_IW-1:0] {
		REG_LEFT_BASE,
		REG_RIGHT_BASE,
		REG_MOD_DEPTH,
		REG_FB_GAIN,
		REG_WET_GAIN
	} msd_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_DELAY,
		ST_ADDR,
		ST_READ,
		ST_INTERP,
		ST_GAIN,
		ST_SUM,
		ST_OUT
	} msd_state_t;

	typedef struct packed {
		logic load;
		logic mod;
		logic dly;
		logic addr;
		logic rd;
		logic interp;
		logic gain;
		logic sum;
		logic out_load;
	} msd_cmd_t;

	// Quarter-wave sine entry k, Q1.15, for a quarter of 2^qbits entries.
	// Taylor series to the 13th power in Q30; evaluated at elaboration.
	function automatic logic [15:0] qsine(input int unsigned k, input int unsigned qbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint s;
		longint v;
		x  = (HALF_PI_Q30 * longint'(k) + (64'd1 << (qbits - 1))) >> qbits;
		x2 = (x * x) >> 30;
		t  = x;
		s  = longint'(x);
		t  = ((t * x2) >> 30) / 6;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 20;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 42;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 72;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 110;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 156;
		s  = s + longint'(t);
		if (s < 0) s = 0;
		v = (s + 16384) >>> 15;
		if (v > 32767) v = 32767;
		return 16'(v);
	endfunction

endpackage

// File: hdl/msd_ifs.sv
// Channel interfaces for the modulated stereo delay: input frames,
// output frames and configuration writes. Depends on msd_pkg.
interface msd_in_if import msd_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;
	logic                          block_last;
	modport source (output valid, left_in, right_in, block_last, input ready);
	modport sink (input valid, left_in, right_in, block_last, output ready);
endinterface

interface msd_out_if import msd_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic                          block_done;
	modport source (output valid, left_out, right_out, block_done, input ready);
	modport sink (input valid, left_out, right_out, block_done, output ready);
endinterface

interface msd_cfg_if import msd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] idx;
	logic [CFG_DW-1:0] data;
	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

// File: hdl/msd_ctrl.sv
// Sequencer for the modulated stereo delay: steps one frame through the
// datapath and owns the input ready and output valid. Depends on msd_pkg.
module msd_ctrl import msd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output msd_cmd_t cmd
);

	msd_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_MOD;
			ST_MOD:    state_d = ST_DELAY;
			ST_DELAY:  state_d = ST_ADDR;
			ST_ADDR:   state_d = ST_READ;
			ST_READ:   state_d = ST_INTERP;
			ST_INTERP: state_d = ST_GAIN;
			ST_GAIN:   state_d = ST_SUM;
			ST_SUM:    state_d = ST_OUT;
			ST_OUT:    if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.mod      = (state_q == ST_MOD);
		cmd.dly      = (state_q == ST_DELAY);
		cmd.addr     = (state_q == ST_ADDR);
		cmd.rd       = (state_q == ST_READ);
		cmd.interp   = (state_q == ST_INTERP);
		cmd.gain     = (state_q == ST_GAIN);
		cmd.sum      = (state_q == ST_SUM);
		cmd.out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hdl/msd_datapath.sv
// Datapath of the modulated stereo delay: config registers, LFOs, sine
// table, delay lines, interpolation, gains and output register. Depends on msd_pkg.
module msd_datapath import msd_pkg::*; #(
	parameter int LINE_DEPTH      = LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  msd_cmd_t                      cmd,
	input  logic                          cfg_we,
	input  logic [CFG_IW-1:0]             cfg_idx,
	input  logic [CFG_DW-1:0]             cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] in_left,
	input  logic signed [SAMPLE_BITS-1:0] in_right,
	input  logic                          in_last,
	output logic signed [SAMPLE_BITS-1:0] out_left,
	output logic signed [SAMPLE_BITS-1:0] out_right,
	output logic                          out_last
);

	localparam int S  = SAMPLE_BITS;
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int QB = SINE_TABLE_BITS - 2;
	localparam int QN = 1 << QB;
	localparam int PW = S + 17;
	localparam logic signed [DLY_W-1:0] DMIN = DLY_W'(256);
	localparam logic signed [DLY_W-1:0] DMAX = DLY_W'((LINE_DEPTH - 2) * 256);
	localparam logic signed [S+2:0] SMAX = (S+3)'((64'sd1 <<< (S - 1)) - 1);
	localparam logic signed [S+2:0] SMIN = (S+3)'(-(64'sd1 <<< (S - 1)));

	function automatic logic signed [S-1:0] sat(input logic signed [S+2:0] v);
		if (v > SMAX) return S'(SMAX);
		if (v < SMIN) return S'(SMIN);
		return S'(v);
	endfunction

	// config
	logic [BASE_W-1:0]  base_q [2];
	logic [DEPTH_W-1:0] depth_q;
	logic [GAIN_W-1:0]  fb_q;
	logic [GAIN_W-1:0]  wet_q;

	// sequencing state
	logic [PHASE_W-1:0] phase_q [2];
	logic [AW-1:0]      wp_q;
	logic [AW:0]        fill_q;

	// payload
	logic signed [S-1:0]    x_q [2];
	logic                   last_q;
	logic [GAIN_W-1:0]      g_q;
	logic signed [31:0]     mprod_s2 [2];
	logic [DLY_W-2:0]       dly_s3 [2];
	logic [AW-1:0]          r0_s4 [2];
	logic [AW-1:0]          r1_s4 [2];
	logic                   v0_s4 [2];
	logic                   v1_s4 [2];
	logic [7:0]             frac_s4 [2];
	logic [7:0]             frac_s5 [2];
	logic                   v0_s5 [2];
	logic                   v1_s5 [2];
	logic [S-1:0]           rd0_s5 [2];
	logic [S-1:0]           rd1_s5 [2];
	logic signed [S-1:0]    y_s6 [2];
	logic signed [PW-1:0]   pfb_s7 [2];
	logic signed [PW-1:0]   pwet_s7 [2];
	logic signed [S-1:0]    res_q [2];
	logic signed [S-1:0]    out_q [2];
	logic                   out_last_q;

	logic [15:0] sine_rom [QN+1];

	for (genvar k = 0; k <= QN; k++) begin : g_rom
		assign sine_rom[k] = qsine(k, QB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0]  <= LEFT_BASE_RST;
			base_q[1]  <= RIGHT_BASE_RST;
			depth_q    <= MOD_DEPTH_RST;
			fb_q       <= FB_GAIN_RST;
			wet_q      <= WET_GAIN_RST;
			phase_q[0] <= '0;
			phase_q[1] <= '0;
			wp_q       <= '0;
			fill_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (msd_reg_t'(cfg_idx))
					REG_LEFT_BASE:  base_q[0] <= cfg_data[BASE_W-1:0];
					REG_RIGHT_BASE: base_q[1] <= cfg_data[BASE_W-1:0];
					REG_MOD_DEPTH:  depth_q   <= cfg_data[DEPTH_W-1:0];
					REG_FB_GAIN:    fb_q      <= cfg_data[GAIN_W-1:0];
					REG_WET_GAIN:   wet_q     <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				phase_q[0] <= phase_q[0] + LFO_L_INC;
				phase_q[1] <= phase_q[1] + LFO_R_INC;
			end
			if (cmd.sum) begin
				wp_q <= (wp_q == AW'(LINE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (fill_q != (AW+1)'(LINE_DEPTH)) fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q[0] <= in_left;
			x_q[1] <= in_right;
			last_q <= in_last;
			g_q    <= GAIN_W'(((32'(fb_q) * 32'(SIX_TENTHS_Q15)) + 32'd16384) >> 15);
		end
		if (cmd.out_load) begin
			out_q[0]   <= res_q[0];
			out_q[1]   <= res_q[1];
			out_last_q <= last_q;
		end
	end

	for (genvar ch = 0; ch < 2; ch++) begin : g_ch
		logic [S-1:0]             line_mem [LINE_DEPTH];
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [QB:0]              ti;
		logic signed [16:0]       sine;
		logic signed [16:0]       modv;
		logic signed [DLY_W-1:0]  dsum;
		logic [DLY_W-2:0]         dcl;
		logic [AW-1:0]            di;
		logic [AW:0]              diff;
		logic [AW-1:0]            r1;
		logic [AW-1:0]            r0;
		logic signed [S-1:0]      t0;
		logic signed [S-1:0]      t1;
		logic signed [S:0]        dt;
		logic signed [S+9:0]      dprod;
		logic signed [S+10:0]     acc;
		logic signed [S+2:0]      fsum;
		logic signed [S+2:0]      wsum;

		always_comb begin
			// sine lookup, quadrant folded onto the quarter table
			idx  = phase_q[ch][PHASE_W-1 -: SINE_TABLE_BITS];
			ti   = idx[QB] ? ((QB+1)'(QN) - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};
			sine = idx[QB+1] ? -$signed({1'b0, sine_rom[ti]}) : $signed({1'b0, sine_rom[ti]});

			// delay, clamped to one..depth-2 samples
			modv = 17'((mprod_s2[ch] + 32'sd16384) >>> 15);
			dsum = $signed({2'b0, base_q[ch]}) + DLY_W'(modv);
			if (dsum < DMIN) dcl = (DLY_W-1)'(DMIN);
			else if (dsum > DMAX) dcl = (DLY_W-1)'(DMAX);
			else dcl = dsum[DLY_W-2:0];

			di   = dly_s3[ch][AW+7:8];
			diff = {1'b0, wp_q} - {1'b0, di};
			r1   = diff[AW] ? AW'(diff + (AW+1)'(LINE_DEPTH)) : diff[AW-1:0];
			r0   = (r1 == '0) ? AW'(LINE_DEPTH - 1) : r1 - 1'b1;

			// entries not yet written since reset read as zero
			t0    = v0_s5[ch] ? $signed(rd0_s5[ch]) : '0;
			t1    = v1_s5[ch] ? $signed(rd1_s5[ch]) : '0;
			dt    = (S+1)'(t1) - (S+1)'(t0);
			dprod = dt * $signed({1'b0, frac_s5[ch]});
			acc   = ((S+11)'(t0) <<< 8) + (S+11)'(dprod) + (S+11)'(128);

			fsum = (S+3)'(x_q[ch]) + (S+3)'((pfb_s7[1-ch] + PW'(16384)) >>> 15);
			wsum = (S+3)'(x_q[ch]) + (S+3)'((pwet_s7[ch] + PW'(16384)) >>> 15);
		end

		always_ff @(posedge clk) begin
			if (cmd.mod) mprod_s2[ch] <= sine * $signed({1'b0, depth_q});
			if (cmd.dly) dly_s3[ch] <= dcl;
			if (cmd.addr) begin
				r0_s4[ch]   <= r0;
				r1_s4[ch]   <= r1;
				v1_s4[ch]   <= ({1'b0, di} <= fill_q);
				v0_s4[ch]   <= (({1'b0, di} + 1'b1) <= fill_q);
				frac_s4[ch] <= dly_s3[ch][7:0];
			end
			if (cmd.rd) begin
				rd0_s5[ch]  <= line_mem[r0_s4[ch]];
				rd1_s5[ch]  <= line_mem[r1_s4[ch]];
				v0_s5[ch]   <= v0_s4[ch];
				v1_s5[ch]   <= v1_s4[ch];
				frac_s5[ch] <= frac_s4[ch];
			end
			if (cmd.interp) y_s6[ch] <= S'(acc >>> 8);
			if (cmd.gain) begin
				pfb_s7[ch]  <= y_s6[ch] * $signed({1'b0, g_q});
				pwet_s7[ch] <= y_s6[ch] * $signed({1'b0, wet_q});
			end
			if (cmd.sum) begin
				line_mem[wp_q] <= sat(fsum);
				res_q[ch]      <= sat(wsum);
			end
		end
	end

	assign out_left  = out_q[0];
	assign out_right = out_q[1];
	assign out_last  = out_last_q;

endmodule

// File: hdl/modulated_stereo_delay_core.sv
// Top level of the modulated stereo delay: sequencer plus datapath.
// Depends on msd_pkg, msd_ifs, msd_ctrl and msd_datapath.
//
//  channel | dir | payload                               | transfer when
//  din     | in  | left_in, right_in, block_last         | din.valid & din.ready
//  dout    | out | left_out, right_out, block_done       | dout.valid & dout.ready
//  cfg     | in  | idx (register 0..4), data             | cfg.valid & cfg.ready
//
// The result is loaded into the output register and dout.valid rises once the din transfer
// has passed LFO/sine multiply, delay clamp, address, read, interpolate, gains, sum and out.
// din.ready is high only in idle, so a new frame is taken only once the last one is in the output register.
// A stalled dout holds the sequencer in its last step only when the next result is ready.
// cfg is always ready. Reset clears LFO phases, write pointer and line fill count;
// unwritten line entries read as zero, so no clearing pass is needed.
module modulated_stereo_delay_core import msd_pkg::*; #(
	parameter int LINE_DEPTH      = LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	msd_in_if.sink      din,
	msd_out_if.source   dout,
	msd_cfg_if.sink     cfg
);

	msd_cmd_t cmd;

	// config registers live in the datapath and take a write every cycle
	assign cfg.ready = 1'b1;

	msd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.cmd       (cmd)
	);

	msd_datapath #(
		.LINE_DEPTH      (LINE_DEPTH),
		.SAMPLE_BITS     (SAMPLE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.idx),
		.cfg_data  (cfg.data),
		.in_left   (din.left_in),
		.in_right  (din.right_in),
		.in_last   (din.block_last),
		.out_left  (dout.left_out),
		.out_right (dout.right_out),
		.out_last  (dout.block_done)
	);

endmodule
